[design/tsp_pkg.sv]
// ----------------------------------------------------------------------------
// tsp_pkg
// shared types and constants for the triple-sphere projection pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsp_pkg;

  localparam int PIX_W      = 24;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [PIX_W-1:0] PIX_MAX = 24'sh7FFFFF;
  localparam logic signed [PIX_W-1:0] PIX_MIN = 24'sh800000;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X   = 4'd0,
    REG_FOCAL_Y   = 4'd1,
    REG_CENTER_X  = 4'd2,
    REG_CENTER_Y  = 4'd3,
    REG_SHIFT_ONE = 4'd4,
    REG_SHIFT_TWO = 4'd5,
    REG_ALPHA     = 4'd6,
    REG_SKEW_PAIR = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_col;
    logic signed [PIX_W-1:0] pixel_row;
    logic                    invalid;
    logic                    clipped;
  } pixel_t;

  // sidebands carried alongside the long arithmetic units
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [63:0]        xy;
  } side_d1_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [36:0] t;
    logic [63:0]        xy;
  } side_t1_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [41:0] t;
    logic [63:0]        xy;
  } side_t2_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [41:0] t;
  } side_d3_t;

  typedef struct packed {
    logic inval;
    logic neg;
  } side_div_t;

endpackage

[design/tsp_square.sv]
// ----------------------------------------------------------------------------
// tsp_square
// two-stage square of a signed value, split into half-width partial products
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsp_square #(
  parameter int AW = 37,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic signed [AW-1:0] in_a,
  input  logic [SW-1:0]        in_side,
  output logic                 out_vld,
  output logic [2*AW-1:0]      out_sq,
  output logic [SW-1:0]        out_side
);

  localparam int LW = (AW + 1) / 2;
  localparam int HW = AW - LW;

  logic [AW-1:0]      mag;
  logic [HW-1:0]      hi;
  logic [LW-1:0]      lo;
  logic               vld1_r, vld2_r;
  logic [2*HW-1:0]    hh_r;
  logic [HW+LW-1:0]   hl_r;
  logic [2*LW-1:0]    ll_r;
  logic [SW-1:0]      side1_r, side2_r;
  logic [2*AW-1:0]    sq_r;

  always_comb begin
    mag = in_a[AW-1] ? AW'(-in_a) : AW'(in_a);
    hi  = mag[AW-1:LW];
    lo  = mag[LW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    hh_r    <= (2*HW)'(hi) * (2*HW)'(hi);
    hl_r    <= (HW+LW)'(hi) * (HW+LW)'(lo);
    ll_r    <= (2*LW)'(lo) * (2*LW)'(lo);
    side1_r <= in_side;
    // hi^2 * 2^2L + 2 * hi * lo * 2^L + lo^2
    sq_r    <= (2*AW)'({hh_r, {(2*LW){1'b0}}})
             + (2*AW)'({hl_r, {(LW+1){1'b0}}})
             + (2*AW)'(ll_r);
    side2_r <= side1_r;
  end

  assign out_vld  = vld2_r;
  assign out_sq   = sq_r;
  assign out_side = side2_r;

endmodule

[design/tsp_sqrt_pipe.sv]
// ----------------------------------------------------------------------------
// tsp_sqrt_pipe
// floor square root, one result bit per register stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsp_sqrt_pipe #(
  parameter int RW = 64,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  logic [RW-1:0]   in_rad,
  input  logic [SW-1:0]   in_side,
  output logic            out_vld,
  output logic [RW/2-1:0] out_root,
  output logic [SW-1:0]   out_side
);

  localparam int QW  = RW / 2;
  localparam int RMW = QW + 2;

  logic [RMW-1:0] rem_r  [QW];
  logic [QW-1:0]  root_r [QW];
  logic [RW-1:0]  rad_r  [QW];
  logic [SW-1:0]  side_r [QW];
  logic           vld_r  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [RMW-1:0] rem_prev;
    logic [QW-1:0]  root_prev;
    logic [RW-1:0]  rad_prev;
    logic [SW-1:0]  side_prev;
    logic           vld_prev;
    logic [RMW+1:0] cand;
    logic [RMW+1:0] trial;
    logic           ge;

    if (s == 0) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign rad_prev  = in_rad;
      assign side_prev = in_side;
      assign vld_prev  = in_vld;
    end else begin : g_next
      assign rem_prev  = rem_r[s-1];
      assign root_prev = root_r[s-1];
      assign rad_prev  = rad_r[s-1];
      assign side_prev = side_r[s-1];
      assign vld_prev  = vld_r[s-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign cand  = {rem_prev, rad_prev[RW-1 -: 2]};
    assign trial = {2'b00, root_prev, 2'b01};
    assign ge    = (cand >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= ge ? RMW'(cand - trial) : cand[RMW-1:0];
      root_r[s] <= {root_prev[QW-2:0], ge};
      rad_r[s]  <= {rad_prev[RW-3:0], 2'b00};
      side_r[s] <= side_prev;
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign out_root = root_r[QW-1];
  assign out_side = side_r[QW-1];

endmodule

[design/tsp_div_pipe.sv]
// ----------------------------------------------------------------------------
// tsp_div_pipe
// unsigned restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsp_div_pipe #(
  parameter int NW = 57,
  parameter int DW = 47,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [NW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic [DW-1:0] rem_r  [NW];
  logic [NW-1:0] quo_r  [NW];
  logic [NW-1:0] num_r  [NW];
  logic [DW-1:0] den_r  [NW];
  logic [SW-1:0] side_r [NW];
  logic          vld_r  [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW-1:0] rem_prev;
    logic [NW-1:0] quo_prev;
    logic [NW-1:0] num_prev;
    logic [DW-1:0] den_prev;
    logic [SW-1:0] side_prev;
    logic          vld_prev;
    logic [DW:0]   part;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_prev  = '0;
      assign quo_prev  = '0;
      assign num_prev  = in_num;
      assign den_prev  = in_den;
      assign side_prev = in_side;
      assign vld_prev  = in_vld;
    end else begin : g_next
      assign rem_prev  = rem_r[s-1];
      assign quo_prev  = quo_r[s-1];
      assign num_prev  = num_r[s-1];
      assign den_prev  = den_r[s-1];
      assign side_prev = side_r[s-1];
      assign vld_prev  = vld_r[s-1];
    end

    assign part = {rem_prev, num_prev[NW-1]};
    assign ge   = (part >= {1'b0, den_prev});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= ge ? DW'(part - {1'b0, den_prev}) : part[DW-1:0];
      quo_r[s]  <= {quo_prev[NW-2:0], ge};
      num_r[s]  <= {num_prev[NW-2:0], 1'b0};
      den_r[s]  <= den_prev;
      side_r[s] <= side_prev;
    end
  end

  assign out_vld  = vld_r[NW-1];
  assign out_quo  = quo_r[NW-1];
  assign out_side = side_r[NW-1];

endmodule

[design/triple_sphere_project.sv]
// ----------------------------------------------------------------------------
// triple_sphere_project
// fixed-point triple-sphere fisheye projection of a camera point to a pixel
// throughput: one point per cycle, busy never rises; the depth is set by
//   three bit-per-stage square roots (32, 37, 42 stages) and the 57-stage divider
// reset: synchronous active-low rst_n clears valid bits and configuration registers to zero
// results cannot be stalled, out_strobe is high for one cycle per result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triple_sphere_project
  import tsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // point input
  input  logic                  start,
  output logic                  busy,
  input  point_t                in_point,
  // pixel output
  output logic                  out_strobe,
  output pixel_t                out_pixel,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic signed [58:0] CLAMP_HI = 59'(PIX_MAX);
  localparam logic signed [58:0] CLAMP_LO = 59'(PIX_MIN);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [23:0]        focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic signed [19:0] shift_one_r, shift_two_r;
  logic [19:0]        alpha_r;
  logic [31:0]        skew_pair_r;
  logic signed [15:0] skew_b, skew_c;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;
  assign skew_b    = $signed(skew_pair_r[31:16]);
  assign skew_c    = $signed(skew_pair_r[15:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r   <= '0;
      focal_y_r   <= '0;
      center_x_r  <= '0;
      center_y_r  <= '0;
      shift_one_r <= '0;
      shift_two_r <= '0;
      alpha_r     <= '0;
      skew_pair_r <= '0;
    end else if (cfg_valid) begin
      // indices past the map are dropped
      case (cfg_reg_t'(cfg_index))
        REG_FOCAL_X:   focal_x_r   <= cfg_data[23:0];
        REG_FOCAL_Y:   focal_y_r   <= cfg_data[23:0];
        REG_CENTER_X:  center_x_r  <= cfg_data[23:0];
        REG_CENTER_Y:  center_y_r  <= cfg_data[23:0];
        REG_SHIFT_ONE: shift_one_r <= $signed(cfg_data[19:0]);
        REG_SHIFT_TWO: shift_two_r <= $signed(cfg_data[19:0]);
        REG_ALPHA:     alpha_r     <= cfg_data[19:0];
        REG_SKEW_PAIR: skew_pair_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // front end: capture, squares of x, y, z, radicand of d1
  // --------------------------------------------------------------------------
  logic               v0_r, v1_r, v2_r;
  logic signed [31:0] x0_r, y0_r, z0_r;
  logic signed [31:0] x1_r, y1_r, z1_r;
  logic [63:0]        xx1_r, yy1_r, zz1_r;
  side_d1_t           sd2_r;
  logic [63:0]        n1_2_r;
  logic [31:0]        ax, ay, az;

  always_comb begin
    ax = x0_r[31] ? 32'(-x0_r) : 32'(x0_r);
    ay = y0_r[31] ? 32'(-y0_r) : 32'(y0_r);
    az = z0_r[31] ? 32'(-z0_r) : 32'(z0_r);
  end

  always_ff @(posedge clk) begin
    x0_r    <= in_point.point_x;
    y0_r    <= in_point.point_y;
    z0_r    <= in_point.point_z;
    x1_r    <= x0_r;
    y1_r    <= y0_r;
    z1_r    <= z0_r;
    xx1_r   <= 64'(ax) * 64'(ax);
    yy1_r   <= 64'(ay) * 64'(ay);
    zz1_r   <= 64'(az) * 64'(az);
    sd2_r.x <= x1_r;
    sd2_r.y <= y1_r;
    sd2_r.z <= z1_r;
    // x^2 + y^2 is reused by the second and third roots
    sd2_r.xy <= xx1_r + yy1_r;
    n1_2_r   <= xx1_r + yy1_r + zz1_r;
  end

  // d1 = |p|
  logic        sq1_vld;
  logic [31:0] d1;
  side_d1_t    sq1_side;

  tsp_sqrt_pipe #(.RW(64), .SW($bits(side_d1_t))) u_sqrt_d1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v2_r),
    .in_rad   (n1_2_r),
    .in_side  (sd2_r),
    .out_vld  (sq1_vld),
    .out_root (d1),
    .out_side (sq1_side)
  );

  // --------------------------------------------------------------------------
  // t1 = z + floor(xi * d1), then t1^2 and the radicand of d2
  // --------------------------------------------------------------------------
  logic               v3_r, v4_r, v5_r;
  logic signed [52:0] p1_3_r;
  side_d1_t           sd3_r;
  side_t1_t           sd4_r, sd5_r;
  logic [73:0]        n2_5_r;
  logic               sqa_vld;
  logic [73:0]        t1_sq;
  side_t1_t           sqa_side;

  always_ff @(posedge clk) begin
    p1_3_r   <= shift_one_r * $signed({1'b0, d1});
    sd3_r    <= sq1_side;
    sd4_r.x  <= sd3_r.x;
    sd4_r.y  <= sd3_r.y;
    sd4_r.xy <= sd3_r.xy;
    // dropping 16 bits of a signed product floors it
    sd4_r.t  <= 37'(sd3_r.z) + $signed(p1_3_r[52:16]);
    sd5_r    <= sqa_side;
    n2_5_r   <= 74'(sqa_side.xy) + t1_sq;
  end

  tsp_square #(.AW(37), .SW($bits(side_t1_t))) u_square_t1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v4_r),
    .in_a     (sd4_r.t),
    .in_side  (sd4_r),
    .out_vld  (sqa_vld),
    .out_sq   (t1_sq),
    .out_side (sqa_side)
  );

  logic        sq2_vld;
  logic [36:0] d2;
  side_t1_t    sq2_side;

  tsp_sqrt_pipe #(.RW(74), .SW($bits(side_t1_t))) u_sqrt_d2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v5_r),
    .in_rad   (n2_5_r),
    .in_side  (sd5_r),
    .out_vld  (sq2_vld),
    .out_root (d2),
    .out_side (sq2_side)
  );

  // --------------------------------------------------------------------------
  // t2 = t1 + floor(lambda * d2), then t2^2 and the radicand of d3
  // --------------------------------------------------------------------------
  logic               v6_r, v7_r, v8_r;
  logic signed [57:0] p2_6_r;
  side_t1_t           sd6_r;
  side_t2_t           sd7_r;
  side_d3_t           sd8_r;
  logic [83:0]        n3_8_r;
  logic               sqb_vld;
  logic [83:0]        t2_sq;
  side_t2_t           sqb_side;

  always_ff @(posedge clk) begin
    p2_6_r   <= shift_two_r * $signed({1'b0, d2});
    sd6_r    <= sq2_side;
    sd7_r.x  <= sd6_r.x;
    sd7_r.y  <= sd6_r.y;
    sd7_r.xy <= sd6_r.xy;
    sd7_r.t  <= 42'(sd6_r.t) + $signed(p2_6_r[57:16]);
    sd8_r.x  <= sqb_side.x;
    sd8_r.y  <= sqb_side.y;
    sd8_r.t  <= sqb_side.t;
    n3_8_r   <= 84'(sqb_side.xy) + t2_sq;
  end

  tsp_square #(.AW(42), .SW($bits(side_t2_t))) u_square_t2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v7_r),
    .in_a     (sd7_r.t),
    .in_side  (sd7_r),
    .out_vld  (sqb_vld),
    .out_sq   (t2_sq),
    .out_side (sqb_side)
  );

  logic        sq3_vld;
  logic [41:0] d3;
  side_d3_t    sq3_side;

  tsp_sqrt_pipe #(.RW(84), .SW($bits(side_d3_t))) u_sqrt_d3 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v8_r),
    .in_rad   (n3_8_r),
    .in_side  (sd8_r),
    .out_vld  (sq3_vld),
    .out_root (d3),
    .out_side (sq3_side)
  );

  // --------------------------------------------------------------------------
  // denominator, intrinsic numerators, rounding offset
  // --------------------------------------------------------------------------
  logic               v9_r, v10_r, v11_r, v12_r;
  logic [61:0]        p3_9_r;
  logic signed [56:0] pfx_9_r, pfy_9_r;
  logic signed [47:0] pb_9_r, pc_9_r;
  logic signed [41:0] t2_9_r;
  logic signed [47:0] den_10_r;
  logic signed [57:0] numc_10_r, numr_10_r;
  logic               inval_11_r, negc_11_r, negr_11_r;
  logic [46:0]        dvs_11_r;
  logic [45:0]        half_11_r;
  logic [56:0]        magc_11_r, magr_11_r;
  logic               inval_12_r, negc_12_r, negr_12_r;
  logic [46:0]        dvs_12_r;
  logic [56:0]        dvdc_12_r, dvdr_12_r;
  logic               den_bad;

  assign den_bad = den_10_r[47] || (den_10_r == '0);

  always_ff @(posedge clk) begin
    // products kept apart from the sums that use them
    p3_9_r  <= 62'(alpha_r) * 62'(d3);
    pfx_9_r <= $signed({1'b0, focal_x_r}) * sq3_side.x;
    pb_9_r  <= skew_b * sq3_side.y;
    pc_9_r  <= skew_c * sq3_side.x;
    pfy_9_r <= $signed({1'b0, focal_y_r}) * sq3_side.y;
    t2_9_r  <= sq3_side.t;

    den_10_r  <= 48'(t2_9_r) + $signed({2'b00, p3_9_r[61:16]});
    numc_10_r <= 58'(pfx_9_r) + 58'(pb_9_r);
    numr_10_r <= 58'(pc_9_r) + 58'(pfy_9_r);

    // a bad denominator divides by one, the result is discarded anyway
    inval_11_r <= den_bad;
    dvs_11_r   <= den_bad ? 47'd1 : den_10_r[46:0];
    half_11_r  <= den_bad ? '0 : den_10_r[46:1];
    negc_11_r  <= numc_10_r[57];
    negr_11_r  <= numr_10_r[57];
    magc_11_r  <= numc_10_r[57] ? 57'(-numc_10_r) : numc_10_r[56:0];
    magr_11_r  <= numr_10_r[57] ? 57'(-numr_10_r) : numr_10_r[56:0];

    // round half away from zero on the magnitude
    inval_12_r <= inval_11_r;
    dvs_12_r   <= dvs_11_r;
    negc_12_r  <= negc_11_r;
    negr_12_r  <= negr_11_r;
    dvdc_12_r  <= magc_11_r + 57'(half_11_r);
    dvdr_12_r  <= magr_11_r + 57'(half_11_r);
  end

  // --------------------------------------------------------------------------
  // two dividers, column and row, in lock step
  // --------------------------------------------------------------------------
  side_div_t   divc_in, divc_out;
  logic        divc_vld, divr_vld;
  logic [56:0] quoc, quor;
  logic        divr_in, divr_out;

  assign divc_in.inval = inval_12_r;
  assign divc_in.neg   = negc_12_r;
  assign divr_in       = negr_12_r;

  tsp_div_pipe #(.NW(57), .DW(47), .SW($bits(side_div_t))) u_div_col (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v12_r),
    .in_num   (dvdc_12_r),
    .in_den   (dvs_12_r),
    .in_side  (divc_in),
    .out_vld  (divc_vld),
    .out_quo  (quoc),
    .out_side (divc_out)
  );

  tsp_div_pipe #(.NW(57), .DW(47), .SW(1)) u_div_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v12_r),
    .in_num   (dvdr_12_r),
    .in_den   (dvs_12_r),
    .in_side  (divr_in),
    .out_vld  (divr_vld),
    .out_quo  (quor),
    .out_side (divr_out)
  );

  // --------------------------------------------------------------------------
  // sign, principal point, saturation
  // --------------------------------------------------------------------------
  logic               v13_r, v14_r, v15_r;
  logic signed [58:0] qc_13_r, qr_13_r, uc_14_r, ur_14_r;
  logic               inval_13_r, inval_14_r;
  logic               hic, loc, hir, lor;
  pixel_t             pix_nxt, pix_r;

  always_comb begin
    hic = (uc_14_r > CLAMP_HI);
    loc = (uc_14_r < CLAMP_LO);
    hir = (ur_14_r > CLAMP_HI);
    lor = (ur_14_r < CLAMP_LO);
    pix_nxt.pixel_col = hic ? PIX_MAX : (loc ? PIX_MIN : uc_14_r[PIX_W-1:0]);
    pix_nxt.pixel_row = hir ? PIX_MAX : (lor ? PIX_MIN : ur_14_r[PIX_W-1:0]);
    pix_nxt.invalid   = 1'b0;
    pix_nxt.clipped   = hic || loc || hir || lor;
    if (inval_14_r) begin
      pix_nxt = '0;
      pix_nxt.invalid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    inval_13_r <= divc_out.inval;
    qc_13_r    <= divc_out.neg ? -$signed({2'b00, quoc}) : $signed({2'b00, quoc});
    qr_13_r    <= divr_out ? -$signed({2'b00, quor}) : $signed({2'b00, quor});
    inval_14_r <= inval_13_r;
    uc_14_r    <= qc_13_r + $signed({35'd0, center_x_r});
    ur_14_r    <= qr_13_r + $signed({35'd0, center_y_r});
    pix_r      <= pix_nxt;
  end

  // valid bits of the top-level stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
      v12_r <= 1'b0;
      v13_r <= 1'b0;
      v14_r <= 1'b0;
      v15_r <= 1'b0;
    end else begin
      v0_r  <= start && !busy;
      v1_r  <= v0_r;
      v2_r  <= v1_r;
      v3_r  <= sq1_vld;
      v4_r  <= v3_r;
      v5_r  <= sqa_vld;
      v6_r  <= sq2_vld;
      v7_r  <= v6_r;
      v8_r  <= sqb_vld;
      v9_r  <= sq3_vld;
      v10_r <= v9_r;
      v11_r <= v10_r;
      v12_r <= v11_r;
      v13_r <= divc_vld;
      v14_r <= v13_r;
      v15_r <= v14_r;
    end
  end

  assign out_strobe = v15_r;
  assign out_pixel  = pix_r;

`ifndef SYNTHESIS
  // the two dividers must never drift apart
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    divc_vld == divr_vld)
    else $error("column and row dividers out of step");

  // a zero divisor would mean the bad-denominator substitution failed
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    v12_r |-> dvs_12_r != '0)
    else $error("divider fed a zero divisor");

  a_invalid_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_pixel.invalid |->
      out_pixel.pixel_col == '0 && out_pixel.pixel_row == '0 && !out_pixel.clipped)
    else $error("invalid beat carries a pixel");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_pixel.clipped |->
      out_pixel.pixel_col == PIX_MAX || out_pixel.pixel_col == PIX_MIN ||
      out_pixel.pixel_row == PIX_MAX || out_pixel.pixel_row == PIX_MIN)
    else $error("clipped beat has no coordinate at a limit");
`endif

endmodule
